/* src/mlfq_pkg.sv */
// ----------------------------------------------------------------------------
// mlfq_pkg
// Command codes and fixed field widths for the multilevel feedback queue
// scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

   // Fixed field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 4;
   localparam int ID_COUNT = 16;

   // Scheduler commands
   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 3'd0,
      CMD_TICK   = 3'd1,
      CMD_YIELD  = 3'd2,
      CMD_BLOCK  = 3'd3,
      CMD_EXIT   = 3'd4,
      CMD_WAKE   = 3'd5
   } cmd_type;

endpackage

`default_nettype wire

/* src/multilevel_feedback_queue_scheduler_top.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// Thread scheduler with LEVELS FIFO ready queues kept in registers.
// ----------------------------------------------------------------------------
// The block takes one scheduling command per clock cycle while the input
// register is not held behind a stalled result, and returns one result word
// per command. A command is taken into the input register; once the result
// register is free or is being taken, a single update of the queue state (up
// to two enqueues, a priority pick of the highest non-empty level and its
// dequeue) loads the result register, which offers the result word. Each level
// keeps the id at its head in a register; after a dequeue the entry behind it
// is fetched from the queue memory by a registered read, in time for the next
// command. A command that arrives while the previous result still waits is
// held in the input register.
// No clearing pass is needed after reset.
`default_nettype none

module multilevel_feedback_queue_scheduler_top #(
   parameter int LEVELS      = 3,
   parameter int MAX_THREADS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [mlfq_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [mlfq_pkg::ID_W-1:0]      req_thread_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [mlfq_pkg::ID_W-1:0]           rsp_running_id,
   output logic                                rsp_running_valid,
   output logic                                rsp_queue_overflow
);

   import mlfq_pkg::*;

   localparam int LW = $clog2(LEVELS);
   localparam int PW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);

   // Advance a queue pointer with wrap at the queue depth
   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Handshake registers
   logic                 s1_valid_ff;
   logic [CMD_W-1:0]     s1_cmd_ff;
   logic [ID_W-1:0]      s1_id_ff;
   logic                 rsp_valid_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic                 rsp_run_ff;
   logic                 rsp_ovf_ff;
   logic                 step;

   // Scheduler state
   logic [ID_W-1:0]      slots_ff [LEVELS][MAX_THREADS];
   logic [PW-1:0]        head_ff  [LEVELS];
   logic [PW-1:0]        tail_ff  [LEVELS];
   logic [CW-1:0]        count_ff [LEVELS];
   logic [LW-1:0]        thread_level_ff [ID_COUNT];
   logic [ID_W-1:0]      cur_ff;
   logic                 cur_valid_ff;

   // Head ids and the refill read
   logic [ID_W-1:0]      head_id_ff [LEVELS];
   logic [ID_W-1:0]      rd_mem_ff;
   logic                 rd_pend_ff;
   logic [LW-1:0]        rd_lvl_ff;
   logic                 rd_fwd_ff;
   logic [ID_W-1:0]      rd_fwd_data_ff;

   // Next-state values
   logic [PW-1:0]        head_in  [LEVELS];
   logic [PW-1:0]        tail_in  [LEVELS];
   logic [CW-1:0]        count_in [LEVELS];
   logic [ID_W-1:0]      head_id_in [LEVELS];
   logic [ID_W-1:0]      cur_in;
   logic                 cur_valid_in;
   logic                 ovf_in;
   logic                 rd_fwd_in;
   logic [ID_W-1:0]      rd_fwd_data_in;

   // Update controls
   logic                 id_ok;
   logic                 is_create, is_tick, is_yield, is_wake, do_select;
   logic [LW-1:0]        cur_lvl, tick_lvl;
   logic                 push_a, push_b, a_full, b_full, wa_en, wb_en;
   logic [LW-1:0]        a_lvl, b_lvl, sel_lvl;
   logic [PW-1:0]        wa_addr, wb_addr, rd_addr;
   logic [ID_W-1:0]      wb_data, sel_data, rd_data;
   logic                 sel_found;
   logic                 rd_en;
   logic                 tl_wr_en;
   logic [ID_W-1:0]      tl_wr_idx;
   logic [LW-1:0]        tl_wr_val;

   // Hold a command until the update stage is free
   assign step      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (step) begin
            s1_valid_ff <= 1'b0;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff <= req_cmd;
         s1_id_ff  <= req_thread_id;
      end
      if (step) begin
         rsp_id_ff  <= cur_valid_in ? cur_in : '0;
         rsp_run_ff <= cur_valid_in;
         rsp_ovf_ff <= ovf_in;
      end
   end

   // Decode the command and work out the enqueue levels
   always_comb begin
      is_create = 1'b0;
      is_tick   = 1'b0;
      is_yield  = 1'b0;
      is_wake   = 1'b0;
      do_select = 1'b0;
      case (cmd_type'(s1_cmd_ff))
         CMD_CREATE: begin
            is_create = 1'b1;
            do_select = 1'b1;
         end
         CMD_TICK: begin
            is_tick   = 1'b1;
            do_select = 1'b1;
         end
         CMD_YIELD: begin
            is_yield  = 1'b1;
            do_select = 1'b1;
         end
         CMD_BLOCK, CMD_EXIT: begin
            do_select = 1'b1;
         end
         CMD_WAKE: begin
            is_wake = 1'b1;
         end
         default: begin
            do_select = 1'b0;
         end
      endcase

      id_ok = int'(s1_id_ff) < MAX_THREADS;
      // A create of the running thread resets its level before the requeue
      cur_lvl  = (is_create && id_ok && (s1_id_ff == cur_ff)) ? '0 : thread_level_ff[cur_ff];
      tick_lvl = (int'(cur_lvl) + 1 < LEVELS) ? cur_lvl + 1'b1 : cur_lvl;

      push_a = (is_create || is_wake) && id_ok;
      a_lvl  = is_create ? '0 : thread_level_ff[s1_id_ff];
      push_b = (is_create || is_tick || is_yield) && cur_valid_ff;
      b_lvl  = is_tick ? tick_lvl : cur_lvl;
      wb_data = cur_ff;

      tl_wr_en  = (is_create && id_ok) || (is_tick && cur_valid_ff);
      tl_wr_idx = is_create ? s1_id_ff : cur_ff;
      tl_wr_val = is_create ? '0 : tick_lvl;
   end

   // Refill data: a forwarded write or the registered memory read
   assign rd_data = rd_fwd_ff ? rd_fwd_data_ff : rd_mem_ff;

   // Apply both enqueues, then pick the head of the highest non-empty level
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         head_in[l]    = head_ff[l];
         tail_in[l]    = tail_ff[l];
         count_in[l]   = count_ff[l];
         head_id_in[l] = (rd_pend_ff && rd_lvl_ff == LW'(l)) ? rd_data : head_id_ff[l];
      end

      // An enqueue into an empty level also becomes its head
      a_full  = count_in[a_lvl] == CW'(MAX_THREADS);
      wa_en   = push_a && !a_full;
      wa_addr = tail_in[a_lvl];
      if (wa_en) begin
         if (count_in[a_lvl] == '0) begin
            head_id_in[a_lvl] = s1_id_ff;
         end
         tail_in[a_lvl]  = ptr_inc(tail_in[a_lvl]);
         count_in[a_lvl] = count_in[a_lvl] + 1'b1;
      end

      b_full  = count_in[b_lvl] == CW'(MAX_THREADS);
      wb_en   = push_b && !b_full;
      wb_addr = tail_in[b_lvl];
      if (wb_en) begin
         if (count_in[b_lvl] == '0) begin
            head_id_in[b_lvl] = wb_data;
         end
         tail_in[b_lvl]  = ptr_inc(tail_in[b_lvl]);
         count_in[b_lvl] = count_in[b_lvl] + 1'b1;
      end

      sel_found = 1'b0;
      sel_lvl   = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (!sel_found && count_in[l] != '0) begin
            sel_found = 1'b1;
            sel_lvl   = LW'(l);
         end
      end

      sel_data = head_id_in[sel_lvl];
      rd_addr  = ptr_inc(head_ff[sel_lvl]);
      rd_en    = 1'b0;

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (do_select) begin
         if (sel_found) begin
            head_in[sel_lvl]  = rd_addr;
            count_in[sel_lvl] = count_in[sel_lvl] - 1'b1;
            cur_in            = sel_data;
            cur_valid_in      = 1'b1;
            // Fetch the next head when the level stays non-empty
            rd_en             = count_in[sel_lvl] != '0;
         end else begin
            cur_in       = '0;
            cur_valid_in = 1'b0;
         end
      end

      // Forward an entry written in this same update to the refill
      rd_fwd_in      = 1'b0;
      rd_fwd_data_in = wb_data;
      if (wb_en && b_lvl == sel_lvl && wb_addr == rd_addr) begin
         rd_fwd_in      = 1'b1;
         rd_fwd_data_in = wb_data;
      end else if (wa_en && a_lvl == sel_lvl && wa_addr == rd_addr) begin
         rd_fwd_in      = 1'b1;
         rd_fwd_data_in = s1_id_ff;
      end

      ovf_in = (push_a && a_full) || (push_b && b_full);
   end

   // Commit the update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         for (int t = 0; t < ID_COUNT; t++) begin
            thread_level_ff[t] <= '0;
         end
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else if (step) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            tail_ff[l]  <= tail_in[l];
            count_ff[l] <= count_in[l];
         end
         if (tl_wr_en) begin
            thread_level_ff[tl_wr_idx] <= tl_wr_val;
         end
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         rd_pend_ff   <= rd_en;
      end
   end

   // Write queue entries, read the refill entry and hold the head ids
   always_ff @(posedge clock) begin
      if (step) begin
         if (wa_en) begin
            slots_ff[a_lvl][wa_addr] <= s1_id_ff;
         end
         if (wb_en) begin
            slots_ff[b_lvl][wb_addr] <= wb_data;
         end
         if (rd_en) begin
            rd_mem_ff <= slots_ff[sel_lvl][rd_addr];
         end
         rd_lvl_ff      <= sel_lvl;
         rd_fwd_ff      <= rd_fwd_in;
         rd_fwd_data_ff <= rd_fwd_data_in;
         for (int l = 0; l < LEVELS; l++) begin
            head_id_ff[l] <= head_id_in[l];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_id     = rsp_id_ff;
   assign rsp_running_valid  = rsp_run_ff;
   assign rsp_queue_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

/* src/mlfq_checker.sv */
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks for the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module mlfq_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic [mlfq_pkg::CMD_W-1:0] req_cmd,
   input wire logic [mlfq_pkg::ID_W-1:0]  req_thread_id,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [mlfq_pkg::ID_W-1:0]  rsp_running_id,
   input wire logic                       rsp_running_valid,
   input wire logic                       rsp_queue_overflow
);

   // Result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_id)
         && $stable(rsp_running_valid) && $stable(rsp_queue_overflow))
      else $error("result word changed while stalled");

   // Main thread running shows id zero
   a_main_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running_valid |-> rsp_running_id == '0)
      else $error("nonzero id while main thread runs");

   // Input side stalls only behind a stalled result
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind multilevel_feedback_queue_scheduler_top mlfq_checker u_mlfq_checker (.*);

`default_nettype wire

/* dv/mlfq_sched_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlfq_sched_checker
// Watches the command and result channels of the scheduler. Each accepted
// command is run through a shadow copy of the ready queues to predict the
// result word. Each accepted result word is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module mlfq_sched_checker #(
   parameter int LEVELS      = 3,
   parameter int MAX_THREADS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [mlfq_pkg::CMD_W-1:0] req_cmd,
   input  logic [mlfq_pkg::ID_W-1:0]  req_thread_id,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [mlfq_pkg::ID_W-1:0]  rsp_running_id,
   input  logic                       rsp_running_valid,
   input  logic                       rsp_queue_overflow,
   output int                         mismatch_count,
   output int                         outcomes_pending
);

   import mlfq_pkg::*;

   localparam int LV_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CNT_W = PTR_W + 1;

   typedef struct packed {
      logic [ID_W-1:0] running_id;
      logic            running_valid;
      logic            queue_overflow;
   } sched_outcome_type;

   // Shadow copy of the ready queues and the running thread
   logic [ID_W-1:0]  slot_ids   [LEVELS][MAX_THREADS];
   logic [PTR_W-1:0] rd_ptr     [LEVELS];
   logic [PTR_W-1:0] wr_ptr     [LEVELS];
   logic [CNT_W-1:0] depth      [LEVELS];
   logic [LV_W-1:0]  home_level [MAX_THREADS];
   logic [ID_W-1:0]  run_id;
   logic             run_valid;

   sched_outcome_type outcome_q [$];
   sched_outcome_type want;

   // Advance a ring pointer, wrapping at the queue depth
   function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
   endfunction

   // Append an id at a level; return one if the level was full
   function automatic logic enqueue_id(int lv, logic [ID_W-1:0] id);
      if (depth[lv] >= MAX_THREADS) begin
         return 1'b1;
      end
      slot_ids[lv][wr_ptr[lv]] = id;
      wr_ptr[lv] = ptr_next(wr_ptr[lv]);
      depth[lv]  = depth[lv] + 1'b1;
      return 1'b0;
   endfunction

   // Run the head of the highest non-empty level, else the main thread
   function automatic void pick_next();
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (depth[lv] != 0) begin
            run_id     = slot_ids[lv][rd_ptr[lv]];
            rd_ptr[lv] = ptr_next(rd_ptr[lv]);
            depth[lv]  = depth[lv] - 1'b1;
            run_valid  = 1'b1;
            return;
         end
      end
      run_id    = '0;
      run_valid = 1'b0;
   endfunction

   // Apply one command to the shadow state and return the result word
   function automatic sched_outcome_type predict_schedule(logic [CMD_W-1:0] cmd,
                                                          logic [ID_W-1:0] id);
      logic              ovf;
      logic [LV_W-1:0]   lv;
      sched_outcome_type res;
      ovf = 1'b0;
      case (cmd)
         CMD_CREATE: begin
            if (id < MAX_THREADS) begin
               home_level[id] = '0;
               ovf |= enqueue_id(0, id);
            end
            if (run_valid) begin
               ovf |= enqueue_id(home_level[run_id], run_id);
            end
            pick_next();
         end
         CMD_TICK: begin
            // demote one level, holding at the lowest
            if (run_valid) begin
               lv = home_level[run_id];
               if (lv < LEVELS - 1) begin
                  lv = lv + 1'b1;
               end
               home_level[run_id] = lv;
               ovf |= enqueue_id(lv, run_id);
            end
            pick_next();
         end
         CMD_YIELD: begin
            if (run_valid) begin
               ovf |= enqueue_id(home_level[run_id], run_id);
            end
            pick_next();
         end
         CMD_BLOCK, CMD_EXIT: begin
            pick_next();
         end
         CMD_WAKE: begin
            if (id < MAX_THREADS) begin
               ovf |= enqueue_id(home_level[id], id);
            end
         end
         default: begin
            // spare codes leave the state alone
         end
      endcase
      res.running_id     = run_valid ? run_id : '0;
      res.running_valid  = run_valid;
      res.queue_overflow = ovf;
      return res;
   endfunction

   function automatic void check_field(string field, int want_v, int got_v);
      if (want_v != got_v) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // Retire result words first, then log the new command
   always @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            rd_ptr[lv] = '0;
            wr_ptr[lv] = '0;
            depth[lv]  = '0;
            for (int s = 0; s < MAX_THREADS; s++) begin
               slot_ids[lv][s] = '0;
            end
         end
         for (int t = 0; t < MAX_THREADS; t++) begin
            home_level[t] = '0;
         end
         run_id    = '0;
         run_valid = 1'b0;
         outcome_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("result word with no command outstanding: id %0d valid %0d ovf %0d",
                      rsp_running_id, rsp_running_valid, rsp_queue_overflow);
               mismatch_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("running_id", want.running_id, rsp_running_id);
               check_field("running_valid", want.running_valid, rsp_running_valid);
               check_field("queue_overflow", want.queue_overflow, rsp_queue_overflow);
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(predict_schedule(req_cmd, req_thread_id));
         end
      end
      outcomes_pending = outcome_q.size();
   end

endmodule

/* dv/multilevel_feedback_queue_scheduler_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top_test
// Drives scheduler commands with random gaps on both channels: a directed
// opening, then random runs of mixed commands, wake bursts that fill the
// queues, drain runs and demotion runs. A long receiver hold-off backs the
// block up. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top_test;

   import mlfq_pkg::*;

   localparam int SCHED_LEVELS    = 3;
   localparam int SCHED_THREADS   = 16;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int WORDS_PER_PHASE = 150;

   // Command codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd       = '0;
   logic [ID_W-1:0]   req_thread_id = '0;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   logic [ID_W-1:0]   rsp_running_id;
   logic              rsp_running_valid;
   logic              rsp_queue_overflow;

   int                mismatch_count;
   int                outcomes_pending;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                holdoff_asked = 0;

   multilevel_feedback_queue_scheduler_top #(
      .LEVELS      (SCHED_LEVELS),
      .MAX_THREADS (SCHED_THREADS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_thread_id      (req_thread_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_running_id     (rsp_running_id),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_queue_overflow (rsp_queue_overflow)
   );

   mlfq_sched_checker #(
      .LEVELS      (SCHED_LEVELS),
      .MAX_THREADS (SCHED_THREADS)
   ) u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_thread_id      (req_thread_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_running_id     (rsp_running_id),
      .rsp_running_valid  (rsp_running_valid),
      .rsp_queue_overflow (rsp_queue_overflow),
      .mismatch_count     (mismatch_count),
      .outcomes_pending   (outcomes_pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      int holdoff_served;
      hold_left      = 0;
      holdoff_served = 0;
      forever begin
         @(negedge clock);
         if (holdoff_served != holdoff_asked) begin
            holdoff_served = holdoff_asked;
            hold_left      = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one command word and hold it until the block takes it
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_cmd       = cmd;
      req_thread_id = id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [CMD_W-1:0] mixed_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 18)      return CMD_CREATE;
      else if (r < 36) return CMD_TICK;
      else if (r < 52) return CMD_YIELD;
      else if (r < 62) return CMD_BLOCK;
      else if (r < 72) return CMD_EXIT;
      else if (r < 95) return CMD_WAKE;
      else             return $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
   endfunction

   // Send runs of commands until n_words scheduling words have gone out
   task automatic random_words(input int n_words);
      int               counted;
      int               pick;
      int               run_len;
      logic [ID_W-1:0]  tid;
      logic [CMD_W-1:0] c;
      counted = 0;
      while (counted < n_words) begin
         pick    = $urandom_range(99);
         run_len = $urandom_range(20, 4);
         tid     = ID_W'($urandom_range(ID_COUNT - 1));
         for (int k = 0; k < run_len && counted < n_words; k++) begin
            if (pick < 40) begin
               c = mixed_cmd();
            end else if (pick < 60) begin
               // wake burst on one id: fills its level
               c = CMD_WAKE;
            end else if (pick < 75) begin
               c = $urandom_range(1) ? CMD_BLOCK : CMD_EXIT;
            end else if ($urandom_range(3) == 0) begin
               c = CMD_CREATE;
            end else begin
               c = $urandom_range(1) ? CMD_TICK : CMD_YIELD;
            end
            if (pick < 40 || pick >= 60) begin
               tid = ID_W'($urandom_range(ID_COUNT - 1));
            end
            send_word(c, tid);
            if (c != CMD_SPARE_6 && c != CMD_SPARE_7) begin
               counted++;
            end
         end
      end
   endtask

   initial begin
      int drain_wait;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 34;
      recv_idle_pct = 77;

      // main thread running: nothing to requeue
      send_word(CMD_SPARE_6, ID_W'(0));
      send_word(CMD_BLOCK, ID_W'(0));
      // lone thread demoted down to the lowest level and held there
      send_word(CMD_CREATE, ID_W'(15));
      send_word(CMD_TICK, ID_W'(0));
      send_word(CMD_TICK, ID_W'(15));
      send_word(CMD_TICK, ID_W'(0));
      send_word(CMD_CREATE, ID_W'(0));
      send_word(CMD_YIELD, ID_W'(15));
      send_word(CMD_EXIT, ID_W'(0));
      send_word(CMD_SPARE_7, ID_W'(15));
      // fill level zero, then overflow it
      for (int k = 0; k < SCHED_THREADS + 1; k++) begin
         send_word(CMD_WAKE, ID_W'(9));
      end

      random_words(WORDS_PER_PHASE);

      send_idle_pct = 77;
      recv_idle_pct = 34;
      random_words(WORDS_PER_PHASE);

      // back the block up: receiver holds off while words keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holdoff_asked++;
      random_words(WORDS_PER_PHASE);

      @(negedge clock);
      req_valid = 1'b0;

      drain_wait = 0;
      while (outcomes_pending != 0 && drain_wait < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && outcomes_pending == 0) begin
         $display("multilevel_feedback_queue_scheduler_top verification clean");
      end else begin
         $display("multilevel_feedback_queue_scheduler_top verification failed");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("multilevel_feedback_queue_scheduler_top verification failed");
      $finish;
   end

endmodule

/* multilevel_feedback_queue_scheduler_top.f */
src/mlfq_pkg.sv
src/multilevel_feedback_queue_scheduler_top.sv
src/mlfq_checker.sv
dv/mlfq_sched_checker.sv
dv/multilevel_feedback_queue_scheduler_top_test.sv
